// File: rtl/core/h32ec_pkg.sv
// Package for the 32-bit Hamming encode/correct core: parity masks,
// the data-bit placement table and the scatter/gather/syndrome functions.
// No dependencies.
`default_nettype none

package h32ec_pkg;

    localparam int unsigned CwWidth   = 32;
    localparam int unsigned DataBits  = 27;
    localparam int unsigned SynBits   = 5;
    localparam int unsigned SpanBits  = 31;

    typedef logic [CwWidth-1:0]   cw_t;
    typedef logic [SynBits-1:0]   syn_t;
    typedef logic [4:0]           bit_idx_t;

    // Function code of a transaction
    typedef enum logic {
        FUNC_ENCODE = 1'b0,
        FUNC_DECODE = 1'b1
    } func_t;

    // Bits of the codeword covered by each parity bit (positions 1..31 only)
    localparam cw_t SYN_MASK [SynBits] = '{
        32'h5555_5555,
        32'h6666_6666,
        32'h7878_7878,
        32'h7F80_7F80,
        32'h7FFF_8000
    };

    // Codeword bit that carries data bit i: parity slots 0, 1, 3, 7, 15 are skipped
    function automatic bit_idx_t data_slot(input int unsigned i);
        int unsigned pos;
        begin
            if (i < 1) begin
                pos = i + 2;
            end else if (i < 4) begin
                pos = i + 3;
            end else if (i < 11) begin
                pos = i + 4;
            end else begin
                pos = i + 5;
            end
            return pos[4:0];
        end
    endfunction

    // Even-parity syndrome over positions 1..31
    function automatic syn_t syndrome(input cw_t cw);
        syn_t s;
        begin
            for (int j = 0; j < SynBits; j++) begin
                s[j] = ^(cw & SYN_MASK[j]);
            end
            return s;
        end
    endfunction

    // Spread the low data bits over the non-parity slots
    function automatic cw_t scatter(input cw_t data);
        cw_t cw;
        begin
            cw = '0;
            for (int unsigned i = 0; i < DataBits; i++) begin
                cw[data_slot(i)] = data[i];
            end
            return cw;
        end
    endfunction

    // Collect the non-parity slots into the low data bits
    function automatic cw_t gather(input cw_t cw);
        cw_t data;
        begin
            data = '0;
            for (int unsigned i = 0; i < DataBits; i++) begin
                data[i] = cw[data_slot(i)];
            end
            return data;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/hamming_32bit_encode_correct_core.sv
// Hamming (SEC) encoder and single-error corrector over a 32-bit word.
//
// Input channel s_valid/s_ready carries s_func (0 encode, 1 decode) and
// s_value (data word, low 27 bits used, or a 32-bit codeword). Result
// channel m_valid/m_ready carries m_result: the codeword when encoding,
// or the corrected 27-bit data word (upper bits zero) when decoding.
// Codeword position 32 carries data but is not protected.
//
// A transaction accepted into the input register passes through the codec
// logic into the result register.
// Throughput: one transaction per cycle while m_ready is high (single codec pass).
// When m_ready is low the result register holds and the input register
// can still take one more transaction; s_ready falls only when both are
// full. Synchronous active-low reset on aresetn empties both stages.
// Depends on h32ec_pkg and h32ec_codec.
`default_nettype none

module hamming_32bit_encode_correct_core
    import h32ec_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire logic s_func,
    input  wire cw_t  s_value,
    output logic      m_valid,
    input  wire logic m_ready,
    output cw_t       m_result
);

    logic in_valid_reg, in_valid_next;
    logic in_func_reg;
    cw_t  in_value_reg;
    logic out_valid_reg, out_valid_next;
    cw_t  result_reg;
    cw_t  result_next;
    logic out_free;
    logic advance;

    // Handshake: each stage moves when the one after it can take the transaction
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !out_free);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    // Hold the input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_valid && s_ready) begin
            in_func_reg  <= s_func;
            in_value_reg <= s_value;
        end
    end

    h32ec_codec u_codec (
        .func   (in_func_reg),
        .value  (in_value_reg),
        .result (result_next)
    );

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = result_reg;

`ifndef SYNTHESIS
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

    a_advance_fills : assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("advanced transaction did not reach result stage");

    a_input_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_value_reg)
            && $stable(in_func_reg))
        else $error("stalled input stage lost its transaction");

    a_ready_when_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input refused while a stage was free");
`endif

endmodule

`default_nettype wire

// File: rtl/core/h32ec_codec.sv
// Combinational encode / single-error-correct datapath for one codeword.
// Depends on h32ec_pkg.
`default_nettype none

module h32ec_codec
    import h32ec_pkg::*;
(
    input  wire logic  func,
    input  wire cw_t   value,
    output cw_t        result
);

    cw_t  spread;
    syn_t enc_syn;
    cw_t  encoded;
    syn_t dec_syn;
    cw_t  fixed;
    cw_t  decoded;

    // Encode: place data, then set each parity bit to clear the syndrome
    always_comb begin
        spread  = scatter(value);
        enc_syn = syndrome(spread);
        encoded = spread;
        for (int j = 0; j < SynBits; j++) begin
            encoded[(1 << j) - 1] = enc_syn[j];
        end
    end

    // Decode: invert the bit named by a nonzero syndrome, then extract data
    always_comb begin
        dec_syn = syndrome(value);
        fixed   = value;
        for (int k = 0; k < SpanBits; k++) begin
            if (dec_syn == syn_t'(k + 1)) begin
                fixed[k] = ~value[k];
            end
        end
        decoded = gather(fixed);
    end

    // Select by function code
    always_comb begin
        case (func_t'(func))
            FUNC_ENCODE: result = encoded;
            FUNC_DECODE: result = decoded;
            default:     result = encoded;
        endcase
    end

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for hamming_32bit_encode_correct_core: encode and
// correct transactions, each checked against a local Hamming (SEC) predictor.
// Depends on h32ec_pkg and the core RTL.

module tb;
    import h32ec_pkg::*;

    typedef struct {
        func_t func;
        cw_t   value;
        bit    hold_until_drained;
    } codec_req_t;

    logic aclk     = 1'b0;
    logic aresetn  = 1'b0;
    logic s_valid  = 1'b0;
    logic s_ready;
    logic s_func   = 1'b0;
    cw_t  s_value  = '0;
    logic m_valid;
    logic m_ready  = 1'b0;
    cw_t  m_result;

    codec_req_t  pending_items[$];
    cw_t         expected_results[$];
    int unsigned mismatch_count = 0;
    int unsigned results_seen   = 0;
    int unsigned cycle_count    = 0;
    int unsigned holdoff_left   = 0;
    bit          holdoff_done   = 1'b0;
    logic        calm;

    hamming_32bit_encode_correct_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_func   (s_func),
        .s_value  (s_value),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    always #1 aclk = ~aclk;

    // Parity positions are the powers of two below 32
    function automatic bit is_check_position(input int unsigned pos);
        return ((pos & (pos - 1)) == 0) && (pos < 32);
    endfunction

    // XOR of the indices of every set position in 1..31
    function automatic syn_t position_syndrome(input cw_t cw);
        syn_t s;
        s = '0;
        for (int unsigned pos = 1; pos <= 31; pos++) begin
            if (cw[pos-1]) begin
                s = s ^ pos[4:0];
            end
        end
        return s;
    endfunction

    function automatic cw_t hamming_codeword(input cw_t data);
        cw_t         cw;
        syn_t        s;
        int unsigned k;
        cw = '0;
        k  = 0;
        for (int unsigned pos = 1; pos <= 32; pos++) begin
            if (!is_check_position(pos)) begin
                cw[pos-1] = data[k];
                k++;
            end
        end
        // Setting check bit 2^j for each set syndrome bit clears the syndrome
        s = position_syndrome(cw);
        for (int unsigned j = 0; j < 5; j++) begin
            if (s[j]) begin
                cw[(1 << j) - 1] = 1'b1;
            end
        end
        return cw;
    endfunction

    function automatic cw_t corrected_data(input cw_t cw);
        cw_t         data;
        syn_t        s;
        int unsigned k;
        data = '0;
        k    = 0;
        s    = position_syndrome(cw);
        if (s != '0) begin
            cw[s - 1] = ~cw[s - 1];
        end
        for (int unsigned pos = 1; pos <= 32; pos++) begin
            if (!is_check_position(pos)) begin
                data[k] = cw[pos-1];
                k++;
            end
        end
        return data;
    endfunction

    task automatic report_mismatch(input string what, input cw_t got, input cw_t want);
        $display("MISMATCH t=%0t result #%0d %s: got %08h want %08h",
                 $time, results_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_item(input func_t func, input cw_t value, input bit hold);
        codec_req_t req;
        req.func               = func;
        req.value              = value;
        req.hold_until_drained = hold;
        pending_items.push_back(req);
    endtask

    // Count cycles; keep a window free of random idling on both sides
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end
    assign calm = (cycle_count >= 60) && (cycle_count < 260);

    // Driver: predict on acceptance, then offer the next pending item
    always @(posedge aclk) begin
        codec_req_t next_req;
        logic       offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (func_t'(s_func) == FUNC_ENCODE) begin
                    expected_results.push_back(hamming_codeword(s_value));
                end else begin
                    expected_results.push_back(corrected_data(s_value));
                end
            end
            if (!s_valid || s_ready) begin
                offer = 1'b0;
                if (pending_items.size() != 0) begin
                    offer = calm || ($urandom_range(0, 99) >= 12);
                    // Hold the marked item until every result has come back
                    if (pending_items[0].hold_until_drained && expected_results.size() != 0) begin
                        offer = 1'b0;
                    end
                end
                if (offer) begin
                    next_req = pending_items.pop_front();
                    s_func  <= next_req.func;
                    s_value <= next_req.value;
                end
                s_valid <= offer;
            end
        end
    end

    // Monitor: check each result transaction, stall at random, one long hold-off
    always @(posedge aclk) begin
        cw_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", m_result, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_result !== want) begin
                        report_mismatch("result", m_result, want);
                    end
                end
            end
            if (holdoff_left != 0) begin
                m_ready      <= 1'b0;
                holdoff_left <= holdoff_left - 1;
            end else if (!holdoff_done && results_seen >= 300) begin
                holdoff_done <= 1'b1;
                holdoff_left <= 40;
                m_ready      <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 12);
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        cw_t         cw;
        cw_t         data;
        int unsigned roll;
        int unsigned flip_a;
        int unsigned flip_b;

        // Directed: field extremes, ignored upper data bits, errors at check,
        // data and unprotected positions, and a double error
        queue_item(FUNC_ENCODE, 32'h0000_0000, 1'b0);
        queue_item(FUNC_ENCODE, 32'h07FF_FFFF, 1'b0);
        queue_item(FUNC_ENCODE, 32'hFFFF_FFFF, 1'b0);
        queue_item(FUNC_ENCODE, 32'hF800_0000, 1'b0);
        queue_item(FUNC_ENCODE, 32'h0000_0001, 1'b0);
        queue_item(FUNC_ENCODE, 32'h0400_0000, 1'b0);
        cw = hamming_codeword(32'h0555_AAAA);
        queue_item(FUNC_DECODE, cw, 1'b0);
        queue_item(FUNC_DECODE, cw ^ 32'h0000_0001, 1'b0);
        queue_item(FUNC_DECODE, cw ^ 32'h0000_0002, 1'b0);
        queue_item(FUNC_DECODE, cw ^ 32'h0000_8000, 1'b0);
        queue_item(FUNC_DECODE, cw ^ 32'h0000_0004, 1'b0);
        queue_item(FUNC_DECODE, cw ^ 32'h4000_0000, 1'b0);
        queue_item(FUNC_DECODE, cw ^ 32'h8000_0000, 1'b0);
        queue_item(FUNC_DECODE, cw ^ 32'h0000_0041, 1'b0);
        queue_item(FUNC_DECODE, 32'h0000_0000, 1'b0);
        queue_item(FUNC_DECODE, 32'hFFFF_FFFF, 1'b0);
        queue_item(FUNC_DECODE, hamming_codeword(32'h07FF_FFFF) ^ 32'h0001_0000, 1'b0);

        // Random: encodes, codewords with no, one or two errors, and some raw words
        for (int i = 0; i < 400; i++) begin
            roll = $urandom_range(0, 9);
            data = $urandom();
            if (roll < 3) begin
                queue_item(FUNC_ENCODE, data, i == 200);
            end else if (roll < 8) begin
                cw     = hamming_codeword(data);
                flip_a = $urandom_range(0, 31);
                flip_b = $urandom_range(0, 31);
                if ($urandom_range(0, 2) != 0) begin
                    cw[flip_a] = ~cw[flip_a];
                end
                if (roll == 7) begin
                    cw[flip_b] = ~cw[flip_b];
                end
                queue_item(FUNC_DECODE, cw, i == 200);
            end else begin
                queue_item(FUNC_DECODE, $urandom(), i == 200);
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: all items sent, all results back, then a quiet wait;
        // sample between edges so the driver's updates have settled
        while (pending_items.size() != 0 || s_valid) begin
            @(negedge aclk);
        end
        while (expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (expected_results.size() != 0) begin
            report_mismatch("transaction never returned", '0, expected_results[0]);
        end
        if (mismatch_count == 0) begin
            $display("hamming_32bit_encode_correct_core test passed");
        end else begin
            $display("hamming_32bit_encode_correct_core test failed");
        end
        $finish;
    end

    // Timeout
    initial begin
        #200000;
        $display("hamming_32bit_encode_correct_core test failed");
        $finish;
    end

endmodule
